>>> src/spql_pkg.sv
// ----------------------------------------------------------------------------
// spql_pkg
// Shared constants and controller/datapath handshake types for the sorted
// insertion priority list.
// ----------------------------------------------------------------------------
package spql_pkg;

    // List geometry
    localparam int DEPTH    = 16;
    localparam int CNT_W    = $clog2(DEPTH + 1);

    // Field widths
    localparam int KEY_W    = 8;
    localparam int CHAR_W   = 8;
    localparam int SEQ_W    = 5;
    localparam int STATUS_W = 16;
    localparam int DROP_W   = 8;

    localparam logic [DROP_W-1:0] DROP_MAX = '1;

    // Request operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DRAIN  = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic latch;      // capture the insert record
        logic insert;     // place the captured record (or count a drop)
        logic seq_clear;  // restart the sequence id for a new drain
        logic load;       // move the head record into the output register
    } spql_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic empty;      // no records held
        logic one_left;   // exactly one record held
    } spql_sts_t;

endpackage

>>> src/sorted_insert_priority_list.sv
// ----------------------------------------------------------------------------
// Insert: request captured on acceptance, record placed in the next cycle.
// Drain: one record per cycle from the row head into the output register
// while the output slot is free; a held record waits there on out_ready.
// A new request is taken once the controller is back in idle.
// Reset clears the count, drop counter and sequence state; the row is not.
// ----------------------------------------------------------------------------
// sorted_insert_priority_list
// Descending-power record list with compare-and-shift insert and in-order
// drain with product status.
// ----------------------------------------------------------------------------
module sorted_insert_priority_list
    import spql_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                func,
    input  logic [KEY_W-1:0]    power,
    input  logic [CHAR_W-1:0]   first_char,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SEQ_W-1:0]    seq_id,
    output logic [KEY_W-1:0]    power_out,
    output logic [CHAR_W-1:0]   char_out,
    output logic [STATUS_W-1:0] status,
    output logic [DROP_W-1:0]   dropped,
    output logic                last
);

    spql_cmd_t cmd;
    spql_sts_t sts;

    spql_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    spql_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .power      (power),
        .first_char (first_char),
        .cmd        (cmd),
        .sts        (sts),
        .seq_id     (seq_id),
        .power_out  (power_out),
        .char_out   (char_out),
        .status     (status),
        .dropped    (dropped),
        .last       (last)
    );

`ifndef SYNTHESIS
    // Not ready in the cycle after taking a request
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("request accepted on back-to-back cycles");

    // Never pull a record from an empty list
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !sts.empty)
    else $error("drain load from empty list");

    // Placement always follows a capture
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> $past(cmd.latch))
    else $error("insert without captured record");
`endif

endmodule

>>> src/spql_ctrl.sv
// ----------------------------------------------------------------------------
// spql_ctrl
// Controller: accepts requests, sequences insert and drain, and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module spql_ctrl
    import spql_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      func,
    output logic      out_valid,
    input  logic      out_ready,
    output spql_cmd_t cmd,
    input  spql_sts_t sts
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_INS   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    // Decode state into commands and next state
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (func == FUNC_INSERT)
                    begin
                        cmd.latch  = 1'b1;
                        state_next = S_INS;
                    end
                    else
                    begin
                        cmd.seq_clear = 1'b1;
                        state_next    = S_DRAIN;
                    end
                end
            end
            S_INS:
            begin
                cmd.insert = 1'b1;
                state_next = S_IDLE;
            end
            S_DRAIN:
            begin
                if (sts.empty)
                begin
                    state_next = S_IDLE;
                end
                else if (slot_free)
                begin
                    cmd.load = 1'b1;
                    if (sts.one_left)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Fill or empty the output slot
    always_comb
    begin
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> src/spql_dp.sv
// ----------------------------------------------------------------------------
// spql_dp
// Datapath: sorted record row with parallel compare-and-shift insert,
// shift-out drain into the output register, drop counter.
// ----------------------------------------------------------------------------
module spql_dp
    import spql_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [KEY_W-1:0]    power,
    input  logic [CHAR_W-1:0]   first_char,
    input  spql_cmd_t           cmd,
    output spql_sts_t           sts,
    output logic [SEQ_W-1:0]    seq_id,
    output logic [KEY_W-1:0]    power_out,
    output logic [CHAR_W-1:0]   char_out,
    output logic [STATUS_W-1:0] status,
    output logic [DROP_W-1:0]   dropped,
    output logic                last
);

    logic [KEY_W-1:0]    key_reg  [DEPTH];
    logic [KEY_W-1:0]    key_next [DEPTH];
    logic [CHAR_W-1:0]   byte_reg [DEPTH];
    logic [CHAR_W-1:0]   byte_next[DEPTH];
    logic [CNT_W-1:0]    count_reg;
    logic [DROP_W-1:0]   drop_reg;
    logic [SEQ_W-1:0]    seq_reg;
    logic [KEY_W-1:0]    pw_reg;
    logic [CHAR_W-1:0]   ch_reg;
    logic [SEQ_W-1:0]    seq_out_reg;
    logic [KEY_W-1:0]    pw_out_reg;
    logic [CHAR_W-1:0]   ch_out_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [DROP_W-1:0]   drop_out_reg;
    logic                last_reg;
    logic [DEPTH-1:0]    at_pos;
    logic [DEPTH-1:0]    ge_pos;
    logic                full;
    logic                head_wins;

    assign full         = (count_reg == CNT_W'(DEPTH));
    assign sts.empty    = (count_reg == '0);
    assign sts.one_left = (count_reg == CNT_W'(1));

    // New record goes to the head when the list is empty or it beats the head
    assign head_wins = (count_reg == '0) || (pw_reg > key_reg[0]);

    // Find the insert position: first slot after the head holding a key
    // not above the new one, or the first free slot
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == 0)
            begin
                at_pos[i] = head_wins;
            end
            else
            begin
                at_pos[i] = head_wins || (CNT_W'(i) >= count_reg) ||
                            (key_reg[i] <= pw_reg);
            end
        end
        ge_pos[0] = at_pos[0];
        for (int i = 1; i < DEPTH; i++)
        begin
            ge_pos[i] = ge_pos[i-1] || at_pos[i];
        end
    end

    // Row next values: shift right on insert, shift left on drain
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            key_next[i]  = key_reg[i];
            byte_next[i] = byte_reg[i];
        end
        if (cmd.insert && !full)
        begin
            if (ge_pos[0])
            begin
                key_next[0]  = pw_reg;
                byte_next[0] = ch_reg;
            end
            for (int i = 1; i < DEPTH; i++)
            begin
                if (ge_pos[i-1])
                begin
                    key_next[i]  = key_reg[i-1];
                    byte_next[i] = byte_reg[i-1];
                end
                else if (ge_pos[i])
                begin
                    key_next[i]  = pw_reg;
                    byte_next[i] = ch_reg;
                end
            end
        end
        else if (cmd.load)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                key_next[i]  = key_reg[i+1];
                byte_next[i] = byte_reg[i+1];
            end
        end
    end

    // Record row and captured request
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            key_reg[i]  <= key_next[i];
            byte_reg[i] <= byte_next[i];
        end
        if (cmd.latch)
        begin
            pw_reg <= power;
            ch_reg <= first_char;
        end
    end

    // Count, drop counter and sequence id
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            drop_reg  <= '0;
            seq_reg   <= '0;
        end
        else
        begin
            if (cmd.insert)
            begin
                if (full)
                begin
                    if (drop_reg != DROP_MAX)
                    begin
                        drop_reg <= drop_reg + DROP_W'(1);
                    end
                end
                else
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            else if (cmd.load)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.seq_clear)
            begin
                seq_reg <= '0;
            end
            else if (cmd.load)
            begin
                seq_reg <= seq_reg + SEQ_W'(1);
            end
        end
    end

    // Output register: take the head record
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            seq_out_reg  <= seq_reg + SEQ_W'(1);
            pw_out_reg   <= key_reg[0];
            ch_out_reg   <= byte_reg[0];
            status_reg   <= STATUS_W'(key_reg[0]) * STATUS_W'(byte_reg[0]);
            drop_out_reg <= drop_reg;
            last_reg     <= sts.one_left;
        end
    end

    assign seq_id    = seq_out_reg;
    assign power_out = pw_out_reg;
    assign char_out  = ch_out_reg;
    assign status    = status_reg;
    assign dropped   = drop_out_reg;
    assign last      = last_reg;

endmodule
